>>> hw/rtl/qnco_pkg.sv
// Package with the shared constants, types and table functions of the quadrature NCO.
`default_nettype none

package qnco_pkg;

    // Accumulator and data widths.
    localparam int ACCUM_WIDTH = 32;
    localparam int TUNE_WIDTH  = 32;
    localparam int IDX_WIDTH   = 8;
    localparam int ACT_WIDTH   = 2;
    localparam int DEG_WIDTH   = 9;
    localparam int SMP_WIDTH   = 16;

    typedef logic [ACCUM_WIDTH-1:0]      t_accum;
    typedef logic [TUNE_WIDTH-1:0]       t_tune;
    typedef logic [IDX_WIDTH-1:0]        t_idx;
    typedef logic [ACT_WIDTH-1:0]        t_action;
    typedef logic signed [DEG_WIDTH-1:0] t_deg;
    typedef logic signed [SMP_WIDTH-1:0] t_sample;

    // Action codes.
    localparam t_action ACT_TICK   = 2'd0;
    localparam t_action ACT_ROTATE = 2'd1;
    localparam t_action ACT_SET    = 2'd2;

    // Recognized angles in degrees.
    localparam t_deg DEG_M180 = -9'sd180;
    localparam t_deg DEG_M135 = -9'sd135;
    localparam t_deg DEG_M90  = -9'sd90;
    localparam t_deg DEG_M45  = -9'sd45;
    localparam t_deg DEG_0    = 9'sd0;
    localparam t_deg DEG_P45  = 9'sd45;
    localparam t_deg DEG_P90  = 9'sd90;
    localparam t_deg DEG_P135 = 9'sd135;
    localparam t_deg DEG_P180 = 9'sd180;

    // Offset steps: 32 steps are 45 degrees; a quarter turn is 64 steps.
    localparam t_idx STEP_45     = 8'd32;
    localparam t_idx STEP_90     = 8'd64;
    localparam t_idx STEP_135    = 8'd96;
    localparam t_idx STEP_180    = 8'd128;
    localparam t_idx STEP_QUARTER = 8'd64;

    // Result of decoding a set angle.
    typedef struct packed {
        logic hit;
        t_idx offset;
    } t_set_dec;

    // Offset increment for a relative rotation; unknown angles add nothing.
    function automatic t_idx rotate_step(t_deg deg);
        t_idx step;
        unique case (deg)
            DEG_M135: step = t_idx'(0) - STEP_135;
            DEG_M90:  step = t_idx'(0) - STEP_90;
            DEG_M45:  step = t_idx'(0) - STEP_45;
            DEG_P45:  step = STEP_45;
            DEG_P90:  step = STEP_90;
            DEG_P135: step = STEP_135;
            DEG_M180,
            DEG_P180: step = STEP_180;
            default:  step = '0;
        endcase
        return step;
    endfunction

    // Absolute offset for a set; minus 180 degrees is not recognized here.
    function automatic t_set_dec set_decode(t_deg deg);
        t_set_dec d;
        d.hit = 1'b1;
        unique case (deg)
            DEG_M135: d.offset = t_idx'(0) - STEP_135;
            DEG_M90:  d.offset = t_idx'(0) - STEP_90;
            DEG_M45:  d.offset = t_idx'(0) - STEP_45;
            DEG_0:    d.offset = '0;
            DEG_P45:  d.offset = STEP_45;
            DEG_P90:  d.offset = STEP_90;
            DEG_P135: d.offset = STEP_135;
            DEG_P180: d.offset = STEP_180;
            default: begin
                d.hit    = 1'b0;
                d.offset = '0;
            end
        endcase
        return d;
    endfunction

    // First quadrant of the Q15 sine, truncated toward zero, 65 points.
    function automatic logic [SMP_WIDTH-1:0] quarter_wave(logic [6:0] q);
        logic [SMP_WIDTH-1:0] v;
        unique case (q)
            7'd0:  v = 16'd0;     7'd1:  v = 16'd804;   7'd2:  v = 16'd1607;
            7'd3:  v = 16'd2410;  7'd4:  v = 16'd3211;  7'd5:  v = 16'd4011;
            7'd6:  v = 16'd4807;  7'd7:  v = 16'd5601;  7'd8:  v = 16'd6392;
            7'd9:  v = 16'd7179;  7'd10: v = 16'd7961;  7'd11: v = 16'd8739;
            7'd12: v = 16'd9511;  7'd13: v = 16'd10278; 7'd14: v = 16'd11038;
            7'd15: v = 16'd11792; 7'd16: v = 16'd12539; 7'd17: v = 16'd13278;
            7'd18: v = 16'd14009; 7'd19: v = 16'd14732; 7'd20: v = 16'd15446;
            7'd21: v = 16'd16150; 7'd22: v = 16'd16845; 7'd23: v = 16'd17530;
            7'd24: v = 16'd18204; 7'd25: v = 16'd18867; 7'd26: v = 16'd19519;
            7'd27: v = 16'd20159; 7'd28: v = 16'd20787; 7'd29: v = 16'd21402;
            7'd30: v = 16'd22004; 7'd31: v = 16'd22594; 7'd32: v = 16'd23169;
            7'd33: v = 16'd23731; 7'd34: v = 16'd24278; 7'd35: v = 16'd24811;
            7'd36: v = 16'd25329; 7'd37: v = 16'd25831; 7'd38: v = 16'd26318;
            7'd39: v = 16'd26789; 7'd40: v = 16'd27244; 7'd41: v = 16'd27683;
            7'd42: v = 16'd28105; 7'd43: v = 16'd28510; 7'd44: v = 16'd28897;
            7'd45: v = 16'd29268; 7'd46: v = 16'd29621; 7'd47: v = 16'd29955;
            7'd48: v = 16'd30272; 7'd49: v = 16'd30571; 7'd50: v = 16'd30851;
            7'd51: v = 16'd31113; 7'd52: v = 16'd31356; 7'd53: v = 16'd31580;
            7'd54: v = 16'd31785; 7'd55: v = 16'd31970; 7'd56: v = 16'd32137;
            7'd57: v = 16'd32284; 7'd58: v = 16'd32412; 7'd59: v = 16'd32520;
            7'd60: v = 16'd32609; 7'd61: v = 16'd32678; 7'd62: v = 16'd32727;
            7'd63: v = 16'd32757; 7'd64: v = 16'd32767;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Full-wave sine built from the quarter wave by symmetry.
    function automatic t_sample sine_lut(t_idx idx);
        logic [5:0]           q;
        logic [1:0]           quad;
        logic [6:0]           qi;
        logic [SMP_WIDTH-1:0] mag;
        q    = idx[5:0];
        quad = idx[7:6];
        qi   = quad[0] ? (7'd64 - {1'b0, q}) : {1'b0, q};
        mag  = quarter_wave(qi);
        return quad[1] ? t_sample'(~mag + 16'd1) : t_sample'(mag);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qnco_in_if.sv
// Handshake channel that carries NCO command items into the block.
`default_nettype none

interface qnco_in_if;
    logic                 valid;
    logic                 ready;
    qnco_pkg::t_action    action;
    qnco_pkg::t_deg       phase_degrees;

    modport source (output valid, output action, output phase_degrees, input ready);
    modport sink   (input valid, input action, input phase_degrees, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qnco_out_if.sv
// Handshake channel that carries quadrature sample pairs out of the block.
`default_nettype none

interface qnco_out_if;
    logic                 valid;
    logic                 ready;
    qnco_pkg::t_sample    cos_out;
    qnco_pkg::t_sample    sin_out;

    modport source (output valid, output cos_out, output sin_out, input ready);
    modport sink   (input valid, input cos_out, input sin_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qnco_sincos.sv
// Dual-read sine table that returns a registered sine and cosine pair for one phase index.
`default_nettype none

module qnco_sincos (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire qnco_pkg::t_idx    i_idx,
    output qnco_pkg::t_sample      o_sin,
    output qnco_pkg::t_sample      o_cos
);
    import qnco_pkg::*;

    t_sample r_sin;
    t_sample r_cos;
    t_sample n_sin;
    t_sample n_cos;

    // Cosine is the sine a quarter turn ahead.
    always_comb begin
        n_sin = sine_lut(i_idx);
        n_cos = sine_lut(i_idx + STEP_QUARTER);
    end

    // Output register loads whenever the pair moves forward.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

>>> hw/rtl/quadrature_nco_with_psk_phase_core.sv
// Top level of the quadrature NCO with PSK phase offset.
// The block takes one command transfer per clock unless stalled. A tick reads the top 8
// accumulator bits plus the 8-bit phase offset as a table index, returns the cosine and sine
// pair via the index register and then the table output register, and advances the accumulator
// by the tuning word; rotate and set transfers only change the offset and return nothing.
// Unstalled throughput is one transfer per cycle, set by the single accumulator add and offset
// update in the accept cycle. A stalled result holds the pipeline only once both stages fill.
`default_nettype none

module quadrature_nco_with_psk_phase_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire qnco_pkg::t_tune  i_cfg_wdata,
    qnco_in_if.sink               i_item,
    qnco_out_if.source            o_result
);
    import qnco_pkg::*;

    t_tune    r_tuning;
    t_accum   r_accum;
    t_accum   n_accum;
    t_idx     r_offset;
    t_idx     n_offset;
    t_idx     r_idx;
    logic     r_s1_vld;
    logic     r_out_vld;
    logic     w_in_acc;
    logic     w_tick;
    logic     w_s2_ready;
    logic     w_s1_ready;
    t_set_dec w_set;

    // Pipeline flow control: each stage moves when the one after it can take it.
    assign w_s2_ready = !r_out_vld || o_result.ready;
    assign w_s1_ready = !r_s1_vld || w_s2_ready;
    assign i_item.ready = w_s1_ready;
    assign w_in_acc = i_item.valid && i_item.ready;
    assign w_tick = w_in_acc && (i_item.action == ACT_TICK);

    // Next accumulator and offset for the accepted command.
    always_comb begin
        w_set    = set_decode(i_item.phase_degrees);
        n_accum  = r_accum;
        n_offset = r_offset;
        if (w_in_acc) begin
            unique case (i_item.action)
                ACT_TICK:   n_accum = r_accum + t_accum'(r_tuning);
                ACT_ROTATE: n_offset = r_offset + rotate_step(i_item.phase_degrees);
                ACT_SET: begin
                    if (w_set.hit) begin
                        n_offset = w_set.offset;
                    end
                end
                default: begin
                    n_accum  = r_accum;
                    n_offset = r_offset;
                end
            endcase
        end
    end

    // Control and phase state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tuning  <= '0;
            r_accum   <= '0;
            r_offset  <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tuning <= i_cfg_wdata;
            end
            r_accum  <= n_accum;
            r_offset <= n_offset;
            if (w_s1_ready) begin
                r_s1_vld <= w_tick;
            end
            if (w_s2_ready) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // Table index register, loaded by a tick transfer.
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_idx <= r_accum[ACCUM_WIDTH-1 -: IDX_WIDTH] + r_offset;
        end
    end

    qnco_sincos u_sincos (
        .i_clk (i_clk),
        .i_en  (r_s1_vld && w_s2_ready),
        .i_idx (r_idx),
        .o_sin (o_result.sin_out),
        .o_cos (o_result.cos_out)
    );

    assign o_result.valid = r_out_vld;

    // A pending index appears only after a tick transfer.
    a_s1_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s1_vld) |-> $past(w_tick))
        else $error("index stage filled without a tick transfer");

    // Commands other than tick leave the accumulator alone.
    a_accum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_item.action != ACT_TICK) |=> $stable(r_accum))
        else $error("accumulator moved on a non-tick transfer");

    // The offset only changes on a rotate or set transfer.
    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_acc && (i_item.action == ACT_ROTATE || i_item.action == ACT_SET))
        |=> $stable(r_offset))
        else $error("phase offset changed without a rotate or set transfer");

    // A pending index is not dropped while the output stage is blocked.
    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_s2_ready) |=> (r_s1_vld && $stable(r_idx)))
        else $error("pending index lost during output stall");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the quadrature NCO with PSK phase offset.
`timescale 1ns / 1ps

module tb_top;
    import qnco_pkg::*;

    localparam int      CYCLE_LIMIT    = 400000;
    localparam int      PHASE_COMMANDS = 300;
    localparam int      DRAIN_CYCLES   = 8;
    localparam int      REPORT_LIMIT   = 10;
    localparam t_action ACT_IGNORED    = 2'd3;

    // First quadrant of the Q15 sine, truncated toward zero.
    localparam int QUARTER_SINE [0:64] = '{
        0, 804, 1607, 2410, 3211, 4011, 4807, 5601, 6392, 7179,
        7961, 8739, 9511, 10278, 11038, 11792, 12539, 13278, 14009, 14732,
        15446, 16150, 16845, 17530, 18204, 18867, 19519, 20159, 20787, 21402,
        22004, 22594, 23169, 23731, 24278, 24811, 25329, 25831, 26318, 26789,
        27244, 27683, 28105, 28510, 28897, 29268, 29621, 29955, 30272, 30571,
        30851, 31113, 31356, 31580, 31785, 31970, 32137, 32284, 32412, 32520,
        32609, 32678, 32727, 32757, 32767
    };

    // Angles that rotate or set may recognize.
    localparam t_deg KNOWN_ANGLES [0:8] = '{
        DEG_M180, DEG_M135, DEG_M90, DEG_M45, DEG_0,
        DEG_P45, DEG_P90, DEG_P135, DEG_P180
    };

    typedef struct {
        t_sample cos_v;
        t_sample sin_v;
    } sample_pair_t;

    // Tracks oscillator state and the sample pairs still owed by the block.
    class nco_scoreboard;
        t_tune        tuning;
        t_accum       accum;
        t_idx         offset;
        sample_pair_t owed[$];
        int unsigned  mismatches;
        int unsigned  ticks;
        int unsigned  rotates;
        int unsigned  sets;
        int unsigned  ignored;

        function new();
            tuning     = '0;
            accum      = '0;
            offset     = '0;
            mismatches = 0;
            ticks      = 0;
            rotates    = 0;
            sets       = 0;
            ignored    = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Full-wave sine from the quarter table, using quadrant symmetry.
        function t_sample table_sine(t_idx idx);
            int mag;
            mag = idx[6] ? QUARTER_SINE[64 - int'(idx[5:0])] : QUARTER_SINE[idx[5:0]];
            return idx[7] ? t_sample'(-mag) : t_sample'(mag);
        endfunction

        // Applies one accepted command and records the sample pair it owes.
        function void note_command(t_action act, t_deg deg);
            t_idx         sin_idx;
            sample_pair_t pair;
            case (act)
                ACT_TICK: begin
                    sin_idx    = accum[ACCUM_WIDTH-1 -: IDX_WIDTH] + offset;
                    pair.sin_v = table_sine(sin_idx);
                    pair.cos_v = table_sine(sin_idx + STEP_QUARTER);
                    owed.push_back(pair);
                    accum      = accum + t_accum'(tuning);
                    ticks++;
                end
                ACT_ROTATE: begin
                    case (deg)
                        DEG_M135:           offset = offset - STEP_135;
                        DEG_M90:            offset = offset - STEP_90;
                        DEG_M45:            offset = offset - STEP_45;
                        DEG_P45:            offset = offset + STEP_45;
                        DEG_P90:            offset = offset + STEP_90;
                        DEG_P135:           offset = offset + STEP_135;
                        DEG_M180, DEG_P180: offset = offset + STEP_180;
                        default:            ;
                    endcase
                    rotates++;
                end
                ACT_SET: begin
                    // Minus 180 degrees is not a recognized set angle.
                    case (deg)
                        DEG_M135: offset = t_idx'(0) - STEP_135;
                        DEG_M90:  offset = t_idx'(0) - STEP_90;
                        DEG_M45:  offset = t_idx'(0) - STEP_45;
                        DEG_0:    offset = '0;
                        DEG_P45:  offset = STEP_45;
                        DEG_P90:  offset = STEP_90;
                        DEG_P135: offset = STEP_135;
                        DEG_P180: offset = STEP_180;
                        default:  ;
                    endcase
                    sets++;
                end
                default: ignored++;
            endcase
        endfunction

        // Compares one accepted sample pair with the oldest one owed.
        function void check_sample(t_sample cos_v, t_sample sin_v);
            sample_pair_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected sample cos %0d sin %0d", $time, cos_v, sin_v);
                return;
            end
            want = owed.pop_front();
            if (want.cos_v !== cos_v || want.sin_v !== sin_v) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: cos expected %0d got %0d, sin expected %0d got %0d",
                             $time, want.cos_v, cos_v, want.sin_v, sin_v);
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          cfg_we;
    t_tune         cfg_wdata;
    int            src_idle_pct  = 0;
    int            sink_stall_pct = 0;
    int unsigned   cycle_count   = 0;
    int unsigned   tunings_used  = 0;
    nco_scoreboard sb = new();

    qnco_in_if  item_if ();
    qnco_out_if res_if ();

    quadrature_nco_with_psk_phase_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (res_if)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result sink: random back-pressure at the current stall rate.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Every accepted result transfer is checked against the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_sample(res_if.cos_out, res_if.sin_out);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_command(input t_action act, input t_deg deg);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid         <= 1'b1;
        item_if.action        <= act;
        item_if.phase_degrees <= deg;
        @(posedge i_clk);
        while (!item_if.ready)
            @(posedge i_clk);
        sb.note_command(act, deg);
        @(negedge i_clk);
    endtask

    // Waits for all owed samples, then lets the pipeline settle.
    task automatic drain();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tuning(input t_tune value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.tuning = value;
        tunings_used++;
    endtask

    // Random commands, mostly recognized angles, with some noise.
    task automatic run_random(input int count);
        t_action act;
        t_deg    deg;
        int      pick;
        int      sent;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 55)
                act = ACT_TICK;
            else if (pick < 75)
                act = ACT_ROTATE;
            else if (pick < 93)
                act = ACT_SET;
            else
                act = ACT_IGNORED;
            if ($urandom_range(99) < 75)
                deg = KNOWN_ANGLES[$urandom_range(8)];
            else
                deg = t_deg'($urandom_range(511));
            send_command(act, deg);
            if (act != ACT_IGNORED)
                sent++;
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        item_if.valid         = 1'b0;
        item_if.action        = ACT_TICK;
        item_if.phase_degrees = DEG_0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every angle for rotate and several for set at the reset tuning word.
        send_command(ACT_TICK, DEG_0);
        send_command(ACT_ROTATE, DEG_P45);
        send_command(ACT_TICK, DEG_0);
        send_command(ACT_ROTATE, DEG_P90);
        send_command(ACT_ROTATE, DEG_P135);
        send_command(ACT_ROTATE, DEG_P180);
        send_command(ACT_ROTATE, DEG_M180);
        send_command(ACT_ROTATE, DEG_M45);
        send_command(ACT_TICK, DEG_0);
        send_command(ACT_ROTATE, DEG_M90);
        send_command(ACT_ROTATE, DEG_M135);
        send_command(ACT_ROTATE, DEG_0);
        send_command(ACT_ROTATE, t_deg'(255));
        send_command(ACT_TICK, DEG_0);
        // A set to minus 180 must leave the offset alone.
        send_command(ACT_SET, DEG_M180);
        send_command(ACT_TICK, DEG_0);
        send_command(ACT_SET, DEG_P135);
        send_command(ACT_SET, DEG_M135);
        send_command(ACT_SET, DEG_M90);
        send_command(ACT_SET, DEG_M45);
        send_command(ACT_TICK, DEG_0);
        send_command(ACT_SET, DEG_P180);
        send_command(ACT_SET, t_deg'(-256));
        send_command(ACT_IGNORED, DEG_P90);
        send_command(ACT_TICK, DEG_0);
        drain();

        // Random phases, each with its own tuning word; the first and last share an idling pattern.
        write_tuning(32'hFFFF_FFFF);
        src_idle_pct = 0;  sink_stall_pct = 0;
        run_random(PHASE_COMMANDS);
        drain();

        write_tuning(32'h0000_0000);
        src_idle_pct = 76; sink_stall_pct = 0;
        run_random(PHASE_COMMANDS);
        drain();

        write_tuning(t_tune'($urandom()));
        src_idle_pct = 0;  sink_stall_pct = 76;
        run_random(PHASE_COMMANDS);
        drain();

        write_tuning(t_tune'($urandom()));
        src_idle_pct = 25; sink_stall_pct = 25;
        run_random(PHASE_COMMANDS);
        drain();

        write_tuning(32'h0080_0001);
        src_idle_pct = 0;  sink_stall_pct = 0;
        run_random(PHASE_COMMANDS);
        drain();

        $display("Run covered %0d ticks, %0d rotates, %0d sets and %0d ignored commands",
                 sb.ticks, sb.rotates, sb.sets, sb.ignored);
        $display("over %0d tuning words and four idling patterns; %0d mismatches.",
                 tunings_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/qnco_pkg.sv
hw/rtl/qnco_in_if.sv
hw/rtl/qnco_out_if.sv
hw/rtl/qnco_sincos.sv
hw/rtl/quadrature_nco_with_psk_phase_core.sv
test/tb_top.sv
